// ----- sv/wsd_pkg.sv -----
// wsd_pkg: types and constants for the websocket frame deframer
// no dependencies; imported by websocket_frame_deframer
`timescale 1ns / 1ps

package wsd_pkg;

   // parser phase
   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_LEN     = 3'd1,
      PH_EXT16   = 3'd2,
      PH_KEY     = 3'd3,
      PH_PAYLOAD = 3'd4
   } phase_type;

   // result kind codes
   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_EMPTY = 2'd1;
   localparam logic [1:0] KIND_DISC  = 2'd2;

   // header constants
   localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
   localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;
   localparam logic [3:0] OPCODE_BINARY  = 4'd2;
   localparam logic [1:0] KEY_LAST_BYTE  = 2'd3;

   // one result word
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       last;
      logic [3:0] frame_opcode;
      logic       fin_bit;
      logic       was_masked;
   } result_type;

endpackage

// ----- sv/websocket_frame_deframer.sv -----
// websocket_frame_deframer: byte-serial websocket frame parser with result skid
// depends on wsd_pkg
`timescale 1ns / 1ps

// Parses a received websocket byte stream, one byte per word on the req_
// channel, and returns payload bytes unmasked with a last flag, an empty-frame
// marker for zero-length frames, or a disconnect for binary, control or
// 64-bit-length frames. Header bytes produce no other result. The block takes one
// byte every clock while req_stall is low: the parser state and the output
// register both update at the accepting edge, so a result is seen on the rsp_
// ports in the cycle after its byte is accepted unless an older result is held.
// A one-word skid behind the output register lets the parser accept while
// a result waits; req_stall rises only while that skid entry is occupied.
module websocket_frame_deframer
   import wsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // input channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   // result channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_data,
   output logic       rsp_last,
   output logic [3:0] rsp_frame_opcode,
   output logic       rsp_fin_bit,
   output logic       rsp_was_masked
);

   // parser state
   phase_type   phase_ff, phase_in;
   logic [3:0]  cur_opcode_ff, cur_opcode_in;
   logic        cur_fin_ff, cur_fin_in;
   logic        mask_on_ff, mask_on_in;
   logic [15:0] payload_len_ff, payload_len_in;
   logic [1:0]  field_cnt_ff, field_cnt_in;
   logic [31:0] mask_key_ff, mask_key_in;
   logic [15:0] payload_cnt_ff, payload_cnt_in;

   // result path
   logic        out_valid_ff, out_valid_in;
   result_type  out_ff, out_in;
   logic        skid_valid_ff, skid_valid_in;
   result_type  skid_ff, skid_in;

   logic        accept;
   logic        take;
   logic        res_valid;
   result_type  res;
   logic [15:0] cnt_inc;
   logic [7:0]  key_byte;
   logic [6:0]  len_code;
   logic        disc_hit;

   assign accept    = req_valid && !req_stall;
   assign take      = out_valid_ff && !rsp_stall;
   assign req_stall = skid_valid_ff;

   // shared decode
   assign cnt_inc  = payload_cnt_ff + 16'd1;
   assign len_code = req_rx_byte[6:0];
   assign disc_hit = (cur_opcode_ff == OPCODE_BINARY) || cur_opcode_ff[3] ||
                     (len_code == LEN_CODE_EXT64);
   always_comb begin
      unique case (payload_cnt_ff[1:0])
         2'd0:    key_byte = mask_key_ff[31:24];
         2'd1:    key_byte = mask_key_ff[23:16];
         2'd2:    key_byte = mask_key_ff[15:8];
         default: key_byte = mask_key_ff[7:0];
      endcase
   end

   // next parser state
   always_comb begin
      phase_in       = phase_ff;
      cur_opcode_in  = cur_opcode_ff;
      cur_fin_in     = cur_fin_ff;
      mask_on_in     = mask_on_ff;
      payload_len_in = payload_len_ff;
      field_cnt_in   = field_cnt_ff;
      mask_key_in    = mask_key_ff;
      payload_cnt_in = payload_cnt_ff;
      unique case (phase_ff)
         PH_LEN: begin
            mask_on_in = req_rx_byte[7];
            if (disc_hit) begin
               phase_in = PH_IDLE;
            end else if (len_code == LEN_CODE_EXT16) begin
               payload_len_in = 16'd0;
               field_cnt_in   = 2'd0;
               phase_in       = PH_EXT16;
            end else begin
               payload_len_in = {9'd0, len_code};
               payload_cnt_in = 16'd0;
               field_cnt_in   = 2'd0;
               if (req_rx_byte[7]) begin
                  phase_in = PH_KEY;
               end else if (len_code == 7'd0) begin
                  phase_in = PH_IDLE;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
         end
         PH_EXT16: begin
            payload_len_in = {payload_len_ff[7:0], req_rx_byte};
            if (field_cnt_ff == 2'd0) begin
               field_cnt_in = 2'd1;
            end else begin
               payload_cnt_in = 16'd0;
               field_cnt_in   = 2'd0;
               if (mask_on_ff) begin
                  phase_in = PH_KEY;
               end else if ({payload_len_ff[7:0], req_rx_byte} == 16'd0) begin
                  phase_in = PH_IDLE;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
         end
         PH_KEY: begin
            mask_key_in = {mask_key_ff[23:0], req_rx_byte};
            if (field_cnt_ff != KEY_LAST_BYTE) begin
               field_cnt_in = field_cnt_ff + 2'd1;
            end else begin
               field_cnt_in = 2'd0;
               phase_in     = (payload_len_ff == 16'd0) ? PH_IDLE : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            payload_cnt_in = cnt_inc;
            if (cnt_inc == payload_len_ff) begin
               phase_in = PH_IDLE;
            end
         end
         default: begin
            cur_fin_in    = req_rx_byte[7];
            cur_opcode_in = req_rx_byte[3:0];
            phase_in      = PH_LEN;
         end
      endcase
   end

   // result produced by this byte
   always_comb begin
      res_valid        = 1'b0;
      res.kind         = KIND_DATA;
      res.data         = 8'd0;
      res.last         = 1'b0;
      res.frame_opcode = cur_opcode_in;
      res.fin_bit      = cur_fin_in;
      res.was_masked   = mask_on_in;
      unique case (phase_ff)
         PH_LEN: begin
            if (disc_hit) begin
               res_valid = 1'b1;
               res.kind  = KIND_DISC;
            end else if (len_code == 7'd0 && !req_rx_byte[7]) begin
               res_valid = 1'b1;
               res.kind  = KIND_EMPTY;
            end
         end
         PH_EXT16: begin
            if (field_cnt_ff != 2'd0 && !mask_on_ff &&
                {payload_len_ff[7:0], req_rx_byte} == 16'd0) begin
               res_valid = 1'b1;
               res.kind  = KIND_EMPTY;
            end
         end
         PH_KEY: begin
            if (field_cnt_ff == KEY_LAST_BYTE && payload_len_ff == 16'd0) begin
               res_valid = 1'b1;
               res.kind  = KIND_EMPTY;
            end
         end
         PH_PAYLOAD: begin
            res_valid = 1'b1;
            res.data  = mask_on_ff ? (req_rx_byte ^ key_byte) : req_rx_byte;
            res.last  = (cnt_inc == payload_len_ff);
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase
   end

   // output register and skid routing
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (take) begin
         out_valid_in = skid_valid_ff;
         out_in       = skid_ff;
         skid_valid_in = 1'b0;
      end
      if (accept && res_valid) begin
         if (!out_valid_ff || take) begin
            out_valid_in = 1'b1;
            out_in       = res;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = res;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         cur_opcode_ff  <= 4'd0;
         cur_fin_ff     <= 1'b0;
         mask_on_ff     <= 1'b0;
         payload_len_ff <= 16'd0;
         field_cnt_ff   <= 2'd0;
         mask_key_ff    <= 32'd0;
         payload_cnt_ff <= 16'd0;
         out_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff       <= phase_in;
            cur_opcode_ff  <= cur_opcode_in;
            cur_fin_ff     <= cur_fin_in;
            mask_on_ff     <= mask_on_in;
            payload_len_ff <= payload_len_in;
            field_cnt_ff   <= field_cnt_in;
            mask_key_ff    <= mask_key_in;
            payload_cnt_ff <= payload_cnt_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // result payload registers
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = out_ff.kind;
   assign rsp_data         = out_ff.data;
   assign rsp_last         = out_ff.last;
   assign rsp_frame_opcode = out_ff.frame_opcode;
   assign rsp_fin_bit      = out_ff.fin_bit;
   assign rsp_was_masked   = out_ff.was_masked;

`ifndef SYNTHESIS
   // skid only fills behind a held output word
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word present without output word");

   // a stalled result is never dropped
   a_out_held: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |=> out_valid_ff)
      else $error("stalled result lost");

   // payload phase always has bytes left to deliver
   a_payload_left: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (payload_cnt_ff < payload_len_ff))
      else $error("payload phase with no bytes left");

   // extended length takes only two bytes
   a_ext16_cnt: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_EXT16) |-> (field_cnt_ff <= 2'd1))
      else $error("extended length byte count overrun");

   // only defined kinds leave the block
   a_kind_valid: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.kind == KIND_DATA || out_ff.kind == KIND_EMPTY ||
                        out_ff.kind == KIND_DISC))
      else $error("undefined result kind");
`endif

endmodule

// ----- tb/sv/wsd_frame_checker.sv -----
// wsd_frame_checker: watches both channels of the websocket frame deframer,
// predicts each result word from the accepted bytes and compares them in order
// depends on wsd_pkg
`timescale 1ns / 1ps

module wsd_frame_checker
   import wsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [1:0] rsp_kind,
   input  logic [7:0] rsp_data,
   input  logic       rsp_last,
   input  logic [3:0] rsp_frame_opcode,
   input  logic       rsp_fin_bit,
   input  logic       rsp_was_masked,
   output int         fault_count,
   output int         words_pending
);

   // parser state mirror
   phase_type   ph;
   logic [3:0]  opc;
   logic        fin;
   logic        masked;
   logic [15:0] plen;
   logic [1:0]  hdr_cnt;
   logic [31:0] key;
   logic [15:0] pcnt;

   result_type  expected_words[$];
   int          fault_total = 0;

   assign fault_count = fault_total;

   task automatic report_fault(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      fault_total++;
   endtask

   function automatic result_type make_word(input logic [1:0] kind, input logic [7:0] data,
                                            input logic last);
      result_type w;
      w.kind         = kind;
      w.data         = data;
      w.last         = last;
      w.frame_opcode = opc;
      w.fin_bit      = fin;
      w.was_masked   = masked;
      return w;
   endfunction

   // end of header: key bytes next, empty marker, or payload
   function automatic bit finish_header(output result_type w);
      w       = '0;
      pcnt    = '0;
      hdr_cnt = '0;
      if (masked) begin
         ph = PH_KEY;
         return 1'b0;
      end
      if (plen == 16'd0) begin
         ph = PH_IDLE;
         w  = make_word(KIND_EMPTY, 8'h00, 1'b0);
         return 1'b1;
      end
      ph = PH_PAYLOAD;
      return 1'b0;
   endfunction

   // advance the parser by one byte; returns 1 when a result word is due
   function automatic bit parse_byte(input logic [7:0] b, output result_type w);
      logic [7:0] d;
      w = '0;
      case (ph)
         PH_LEN: begin
            masked = b[7];
            if (opc == OPCODE_BINARY || opc[3] || b[6:0] == LEN_CODE_EXT64) begin
               ph = PH_IDLE;
               w  = make_word(KIND_DISC, 8'h00, 1'b0);
               return 1'b1;
            end
            if (b[6:0] == LEN_CODE_EXT16) begin
               plen    = '0;
               hdr_cnt = '0;
               ph      = PH_EXT16;
               return 1'b0;
            end
            plen = {9'd0, b[6:0]};
            return finish_header(w);
         end
         PH_EXT16: begin
            plen = {plen[7:0], b};
            if (hdr_cnt == 2'd0) begin
               hdr_cnt = 2'd1;
               return 1'b0;
            end
            return finish_header(w);
         end
         PH_KEY: begin
            key = {key[23:0], b};
            if (hdr_cnt < KEY_LAST_BYTE) begin
               hdr_cnt = hdr_cnt + 2'd1;
               return 1'b0;
            end
            hdr_cnt = '0;
            if (plen == 16'd0) begin
               ph = PH_IDLE;
               w  = make_word(KIND_EMPTY, 8'h00, 1'b0);
               return 1'b1;
            end
            ph = PH_PAYLOAD;
            return 1'b0;
         end
         PH_PAYLOAD: begin
            // key byte j mod 4, first key byte in the top bits
            d    = masked ? (b ^ key[8 * (3 - pcnt[1:0]) +: 8]) : b;
            pcnt = pcnt + 16'd1;
            if (pcnt == plen) begin
               ph = PH_IDLE;
               w  = make_word(KIND_DATA, d, 1'b1);
            end else begin
               w  = make_word(KIND_DATA, d, 1'b0);
            end
            return 1'b1;
         end
         default: begin
            fin = b[7];
            opc = b[3:0];
            ph  = PH_LEN;
            return 1'b0;
         end
      endcase
   endfunction

   // predict on accepted bytes, compare on accepted result words
   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (reset) begin
         ph      = PH_IDLE;
         opc     = '0;
         fin     = 1'b0;
         masked  = 1'b0;
         plen    = '0;
         hdr_cnt = '0;
         key     = '0;
         pcnt    = '0;
         expected_words.delete();
      end else begin
         if (req_valid && !req_stall) begin
            if (parse_byte(req_rx_byte, want))
               expected_words.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            got.kind         = rsp_kind;
            got.data         = rsp_data;
            got.last         = rsp_last;
            got.frame_opcode = rsp_frame_opcode;
            got.fin_bit      = rsp_fin_bit;
            got.was_masked   = rsp_was_masked;
            if (expected_words.size() == 0) begin
               report_fault($sformatf("result word with none expected (kind %0d data %02h)",
                                      got.kind, got.data));
            end else begin
               want = expected_words.pop_front();
               if (got.kind !== want.kind)
                  report_fault($sformatf("kind got %0d expected %0d", got.kind, want.kind));
               if (got.data !== want.data)
                  report_fault($sformatf("data got %02h expected %02h", got.data, want.data));
               if (got.last !== want.last)
                  report_fault($sformatf("last got %0b expected %0b", got.last, want.last));
               if (got.frame_opcode !== want.frame_opcode)
                  report_fault($sformatf("frame_opcode got %0h expected %0h",
                                         got.frame_opcode, want.frame_opcode));
               if (got.fin_bit !== want.fin_bit)
                  report_fault($sformatf("fin_bit got %0b expected %0b",
                                         got.fin_bit, want.fin_bit));
               if (got.was_masked !== want.was_masked)
                  report_fault($sformatf("was_masked got %0b expected %0b",
                                         got.was_masked, want.was_masked));
            end
         end
      end
      words_pending <= expected_words.size();
   end

endmodule

// ----- tb/sv/tb_top.sv -----
// tb_top: stimulus and verdict for the websocket frame deframer
// depends on wsd_pkg, websocket_frame_deframer and wsd_frame_checker
`timescale 1ns / 1ps

module tb_top
   import wsd_pkg::*;
();

   localparam int RANDOM_BYTES = 550;
   localparam int DIRECTED_COUNT = 26;

   // hand-picked frames: masked text, empty unmasked, empty masked, binary,
   // close, 64-bit length, reserved opcode with 16-bit length
   localparam logic [7:0] DIRECTED_BYTES [DIRECTED_COUNT] = '{
      8'h01, 8'h81, 8'hA5, 8'h0F, 8'hF0, 8'h5A, 8'h00,
      8'h81, 8'h00,
      8'h80, 8'h80, 8'hFF, 8'h00, 8'hFF, 8'h00,
      8'h82, 8'h05,
      8'h88, 8'h80,
      8'h81, 8'h7F,
      8'hF7, 8'h7E, 8'h00, 8'h01, 8'hFF
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_data;
   logic       rsp_last;
   logic [3:0] rsp_frame_opcode;
   logic       rsp_fin_bit;
   logic       rsp_was_masked;

   int fault_count;
   int words_pending;
   int bytes_sent = 0;
   bit tx_steady = 1'b0;
   bit rx_steady = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   websocket_frame_deframer uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_data         (rsp_data),
      .rsp_last         (rsp_last),
      .rsp_frame_opcode (rsp_frame_opcode),
      .rsp_fin_bit      (rsp_fin_bit),
      .rsp_was_masked   (rsp_was_masked)
   );

   wsd_frame_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_data         (rsp_data),
      .rsp_last         (rsp_last),
      .rsp_frame_opcode (rsp_frame_opcode),
      .rsp_fin_bit      (rsp_fin_bit),
      .rsp_was_masked   (rsp_was_masked),
      .fault_count      (fault_count),
      .words_pending    (words_pending)
   );

   // one byte word: optional gap, then hold until accepted
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = tx_steady ? 0 : $urandom_range(0, 11);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   // stop sending until every predicted word has come back
   task automatic hold_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (words_pending != 0) @(posedge clock);
   endtask

   // result side: random stall per word, stretches with none
   initial begin : result_drain
      int n;
      int taken;
      taken = 0;
      forever begin
         if (taken % 16 == 0)
            rx_steady = ($urandom_range(0, 3) == 0);
         n = rx_steady ? 0 : $urandom_range(0, 11);
         if (n > 0) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         taken++;
      end
   end

   initial begin : watchdog
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      logic [7:0] frame_q[$];
      logic [7:0] hdr;
      logic [6:0] code;
      logic [3:0] opc;
      logic       mask_bit;
      logic [15:0] ext_len;
      int pick;
      int sel;
      int plen;
      bit ext;
      bit stop;
      bit big_sent;
      bit paused;
      big_sent = 1'b0;
      paused   = 1'b0;

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // directed frames
      foreach (DIRECTED_BYTES[i])
         send_byte(DIRECTED_BYTES[i]);
      hold_until_drained();

      // random frames, mostly well formed
      while (bytes_sent < DIRECTED_COUNT + RANDOM_BYTES) begin
         if (!paused && bytes_sent > DIRECTED_COUNT + RANDOM_BYTES / 2) begin
            hold_until_drained();
            paused = 1'b1;
         end
         frame_q.delete();
         tx_steady = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            // raw noise bytes
            repeat ($urandom_range(1, 6)) frame_q.push_back(8'($urandom));
         end else begin
            sel = $urandom_range(0, 19);
            if (sel == 0)
               opc = OPCODE_BINARY;
            else if (sel == 1)
               opc = {1'b1, 3'($urandom)};
            else begin
               sel = $urandom_range(0, 6);
               opc = (sel < 2) ? 4'(sel) : 4'(sel + 1);
            end
            hdr      = {1'($urandom), 3'($urandom), opc};
            mask_bit = 1'($urandom);
            stop     = (opc == OPCODE_BINARY) || opc[3];
            ext      = 1'b0;
            plen     = 0;
            sel      = $urandom_range(0, 29);
            if (sel == 0) begin
               code = LEN_CODE_EXT64;
               stop = 1'b1;
            end else if (sel <= 4) begin
               code = LEN_CODE_EXT16;
               ext  = 1'b1;
               if (sel == 4 && !big_sent) begin
                  plen     = $urandom_range(256, 300);
                  big_sent = 1'b1;
               end else begin
                  plen = $urandom_range(0, 20);
               end
            end else if (sel <= 6) begin
               code = 7'($urandom_range(13, 125));
               plen = code;
            end else begin
               code = 7'($urandom_range(0, 12));
               plen = code;
            end
            frame_q.push_back(hdr);
            frame_q.push_back({mask_bit, code});
            if (!stop) begin
               ext_len = 16'(plen);
               if (ext) begin
                  frame_q.push_back(ext_len[15:8]);
                  frame_q.push_back(ext_len[7:0]);
               end
               if (mask_bit)
                  repeat (4) frame_q.push_back(8'($urandom));
               repeat (plen) frame_q.push_back(8'($urandom));
               // now and then a frame cut short
               if ($urandom_range(0, 19) == 0)
                  repeat ($urandom_range(1, frame_q.size() - 1)) void'(frame_q.pop_back());
            end
         end
         foreach (frame_q[i])
            send_byte(frame_q[i]);
      end

      // drain and settle
      hold_until_drained();
      repeat (20) @(posedge clock);
      if (fault_count == 0 && words_pending == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ----- files.f -----
sv/wsd_pkg.sv
sv/websocket_frame_deframer.sv
tb/sv/wsd_frame_checker.sv
tb/sv/tb_top.sv
